// ----- src/token_bucket_packet_shaper_macros.svh -----
// Assertion macros for the token bucket packet shaper.
// Used by the top level only; needs no package.
`ifndef TOKEN_BUCKET_PACKET_SHAPER_MACROS_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_MACROS_SVH

// same-cycle implication
`define TBPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbps assertion failed");

// next-cycle implication
`define TBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbps assertion failed");

`endif

// ----- src/tbps_pkg.sv -----
// Shared types and constants of the token bucket packet shaper.
// No dependencies; used by every module of the block.
package tbps_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int TOKEN_W  = 10;
  localparam int NUMBER_W = 16;
  localparam int KIND_W   = 3;
  localparam int COUNT_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [TOKEN_W-1:0]  BUCKET_DEPTH_RST = 10'd10;
  localparam logic [NUMBER_W-1:0] PACKET_LIMIT_RST = 16'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_DEPTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT = 1'd1;

  localparam logic CMD_TOKEN  = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  localparam logic [KIND_W-1:0] EV_TOKEN_ADDED   = 3'd0;
  localparam logic [KIND_W-1:0] EV_TOKEN_DROPPED = 3'd1;
  localparam logic [KIND_W-1:0] EV_PKT_QUEUED    = 3'd2;
  localparam logic [KIND_W-1:0] EV_PKT_TOO_BIG   = 3'd3;
  localparam logic [KIND_W-1:0] EV_QUEUE_FULL    = 3'd4;
  localparam logic [KIND_W-1:0] EV_IGNORED       = 3'd5;

  typedef struct packed {
    logic               cmd;
    logic [TOKEN_W-1:0] tokens_needed;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]   event_kind;
    logic [NUMBER_W-1:0] item_number;
    logic                released;
    logic [NUMBER_W-1:0] released_number;
    logic [TOKEN_W-1:0]  released_need;
    logic [TOKEN_W-1:0]  tokens_now;
    logic [COUNT_W-1:0]  queue_count;
    logic                finished;
  } out_t;

  typedef struct packed {
    logic [NUMBER_W-1:0] number;
    logic [TOKEN_W-1:0]  need;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- src/token_bucket_packet_shaper.sv -----
// Token bucket packet shaper: top level with bucket, counters and packet queue.
// Depends on tbps_pkg, tbps_cell, tbps_skid and the assertion macro header.
//
// Usage: each input beat on in_data is a token arrival (cmd 0) or a packet
// arrival (cmd 1, with its token need). Each accepted beat yields exactly one
// result beat on out_data: what happened to the item, any packet released
// from the queue, bucket level, queue occupancy and the finished flag.
// Both channels use valid/stall; a beat moves when valid is high, stall low.
// cfg_we/cfg_index/cfg_data write bucket_depth and packet_limit; writing
// packet_limit also reloads the arrivals-left counter. Write only when idle.
// The result is registered in the output register, or in the skid stage
// while the output is stalled. One beat per cycle while in_stall is low;
// each event resolves combinationally against the head cell of the queue,
// a row of cells shifting one place towards the head on each release.
// Reset: bucket empty, queue empty, counters zero but arrivals-left 20, depth 10, limit 20.
// A stalled receiver fills the output register then the skid stage; in_stall
// rises only once both hold a result, and falls as soon as one drains.
module token_bucket_packet_shaper #(
  parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tbps_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tbps_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  `include "token_bucket_packet_shaper_macros.svh"

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  logic [tbps_pkg::TOKEN_W-1:0]  depth_r, depth_nxt;
  logic [tbps_pkg::NUMBER_W-1:0] limit_r, limit_nxt;
  logic [tbps_pkg::TOKEN_W-1:0]  tokens_r, tokens_nxt;
  logic [tbps_pkg::NUMBER_W-1:0] pkts_r, pkts_nxt;
  logic [tbps_pkg::NUMBER_W-1:0] toks_seen_r, toks_seen_nxt;
  logic [tbps_pkg::NUMBER_W-1:0] left_r, left_nxt;
  logic [FILL_W-1:0]             fill_r, fill_nxt;

  logic [tbps_pkg::TOKEN_W-1:0]  tok_mid;
  logic                          in_acc;
  logic                          done;
  logic                          push, pop;
  tbps_pkg::entry_t              push_entry;
  tbps_pkg::entry_t              head;
  tbps_pkg::entry_t              cell_q [QUEUE_DEPTH];
  tbps_pkg::out_t                res;

  assign in_acc = in_valid && !in_stall;
  assign done   = (left_r == '0) && (fill_r == '0);
  assign head   = cell_q[0];
  assign push_entry.number = pkts_r + 16'd1;
  assign push_entry.need   = in_data.tokens_needed;

  always_comb begin
    depth_nxt     = depth_r;
    limit_nxt     = limit_r;
    tokens_nxt    = tokens_r;
    pkts_nxt      = pkts_r;
    toks_seen_nxt = toks_seen_r;
    left_nxt      = left_r;
    fill_nxt      = fill_r;
    tok_mid       = tokens_r;
    push          = 1'b0;
    pop           = 1'b0;
    res           = '0;
    res.event_kind = tbps_pkg::EV_IGNORED;

    if (in_acc && !done) begin
      if (in_data.cmd == tbps_pkg::CMD_TOKEN) begin
        toks_seen_nxt   = toks_seen_r + 16'd1;
        res.item_number = toks_seen_nxt;
        if (tokens_r < depth_r) begin
          tok_mid        = tokens_r + 10'd1;
          res.event_kind = tbps_pkg::EV_TOKEN_ADDED;
        end else begin
          res.event_kind = tbps_pkg::EV_TOKEN_DROPPED;
        end
        tokens_nxt = tok_mid;
        if ((fill_r != '0) && (head.need <= tok_mid)) begin
          pop                 = 1'b1;
          tokens_nxt          = tok_mid - head.need;
          fill_nxt            = fill_r - FILL_W'(1);
          res.released        = 1'b1;
          res.released_number = head.number;
          res.released_need   = head.need;
        end
      end else if (left_r != '0) begin
        pkts_nxt        = push_entry.number;
        res.item_number = push_entry.number;
        left_nxt        = left_r - 16'd1;
        if (in_data.tokens_needed > depth_r) begin
          res.event_kind = tbps_pkg::EV_PKT_TOO_BIG;
        end else if (fill_r == FILL_MAX) begin
          res.event_kind = tbps_pkg::EV_QUEUE_FULL;
        end else begin
          res.event_kind = tbps_pkg::EV_PKT_QUEUED;
          if ((fill_r == '0) && (in_data.tokens_needed <= tokens_r)) begin
            // empty queue and enough tokens: leaves straight away
            tokens_nxt          = tokens_r - in_data.tokens_needed;
            res.released        = 1'b1;
            res.released_number = push_entry.number;
            res.released_need   = in_data.tokens_needed;
          end else begin
            push     = 1'b1;
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
      end
    end

    res.tokens_now  = tokens_nxt;
    res.queue_count = tbps_pkg::COUNT_W'(fill_nxt);
    res.finished    = (left_nxt == '0) && (fill_nxt == '0);

    if (cfg_we && (cfg_index == tbps_pkg::CFG_BUCKET_DEPTH)) begin
      depth_nxt = cfg_data[tbps_pkg::TOKEN_W-1:0];
    end
    if (cfg_we && (cfg_index == tbps_pkg::CFG_PACKET_LIMIT)) begin
      limit_nxt = cfg_data;
      left_nxt  = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= tbps_pkg::BUCKET_DEPTH_RST;
      limit_r     <= tbps_pkg::PACKET_LIMIT_RST;
      tokens_r    <= '0;
      pkts_r      <= '0;
      toks_seen_r <= '0;
      left_r      <= tbps_pkg::PACKET_LIMIT_RST;
      fill_r      <= '0;
    end else begin
      depth_r     <= depth_nxt;
      limit_r     <= limit_nxt;
      tokens_r    <= tokens_nxt;
      pkts_r      <= pkts_nxt;
      toks_seen_r <= toks_seen_nxt;
      left_r      <= left_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // queue: cell 0 is the head, a push lands in the first free cell
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tbps_pkg::cell_ctrl_t ctrl;
    tbps_pkg::entry_t     shift_in;
    assign ctrl.load  = push && (fill_r == FILL_W'(i));
    assign ctrl.shift = pop;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign shift_in = push_entry;
    end else begin : g_mid
      assign shift_in = cell_q[i+1];
    end
    tbps_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_data  (push_entry),
      .shift_data (shift_in),
      .data_q     (cell_q[i])
    );
  end

  tbps_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_acc),
    .push_data  (res),
    .full       (in_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

  `TBPS_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_MAX)
  `TBPS_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, (fill_r != '0) && !push)
  `TBPS_ASSERT_IMPL(a_skid_behind_main, clk, rst_n, in_stall, out_valid)
  `TBPS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_acc, out_valid)
  `TBPS_ASSERT_NEXT(a_no_overfill, clk, rst_n,
    in_acc && !cfg_we && (tokens_r >= depth_r), tokens_r <= $past(tokens_r))

endmodule

// ----- src/tbps_cell.sv -----
// One slot of the shifting packet queue: takes a new packet or its neighbour's.
// Depends on tbps_pkg.
module tbps_cell (
  input  logic                clk,
  input  tbps_pkg::cell_ctrl_t ctrl,
  input  tbps_pkg::entry_t    load_data,
  input  tbps_pkg::entry_t    shift_data,
  output tbps_pkg::entry_t    data_q
);

  tbps_pkg::entry_t data_r;
  tbps_pkg::entry_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = load_data;
    end else if (ctrl.shift) begin
      data_nxt = shift_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ----- src/tbps_skid.sv -----
// Two-entry result buffer: output register plus skid stage.
// Depends on tbps_pkg.
module tbps_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  tbps_pkg::out_t   push_data,
  output logic             full,
  output logic             out_valid,
  output tbps_pkg::out_t   out_data,
  input  logic             out_stall
);

  logic           main_v_r, main_v_nxt;
  logic           skid_v_r, skid_v_nxt;
  tbps_pkg::out_t main_d_r, main_d_nxt;
  tbps_pkg::out_t skid_d_r, skid_d_nxt;
  logic           take;

  assign take = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push_valid) begin
      if (!main_v_r || take) begin
        main_d_nxt = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule
